@@ src/swmd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmd_pkg: shared types and constants of the sliding window median block
// Widths, window limits, register decode and the structs that link the
// sorted cell chain, the sum tree and the top level.
// ----------------------------------------------------------------------------
package swmd_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_W    = 32;
  localparam int WLEN_W      = 7;
  localparam int IDX_W       = $clog2(MAX_WINDOW);
  localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
  localparam int DIST_W      = SAMPLE_W;
  localparam int DSUM_W      = SAMPLE_W + IDX_W;
  localparam int TREE_LEVELS = IDX_W;
  localparam int TREE_LEAVES = 1 << TREE_LEVELS;
  localparam int TREE_NODES  = 2 * TREE_LEAVES - 1;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register select: paddr bit above the word offset picks the register.
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(3);

  typedef struct packed {
    logic                       ins;
    logic                       rem;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] r;
    logic signed [SAMPLE_W-1:0] med;
    logic [IDX_W-1:0]           oldest;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] val;
    logic [IDX_W-1:0]           age;
    logic                       gt;
  } swmd_link_t;

  typedef struct packed {
    logic load;
    logic adv;
  } tree_ctl_t;

  // Clamp the requested length to [1, MAX_WINDOW].
  function automatic logic [LEN_W-1:0] clamp_len(logic [WLEN_W-1:0] wl);
    logic [LEN_W-1:0] len;
    if (wl == '0) begin
      len = LEN_W'(1);
    end else if (int'(wl) > MAX_WINDOW) begin
      len = LEN_W'(MAX_WINDOW);
    end else begin
      len = LEN_W'(wl);
    end
    return len;
  endfunction

  // Sorted position of the lower median.
  function automatic logic [IDX_W-1:0] len_mid(logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] t;
    t = len - LEN_W'(1);
    t = t >> 1;
    return t[IDX_W-1:0];
  endfunction

  // Age of the oldest sample in a full window.
  function automatic logic [IDX_W-1:0] len_last(logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] t;
    t = len - LEN_W'(1);
    return t[IDX_W-1:0];
  endfunction

  localparam logic [LEN_W-1:0] LEN_RESET = clamp_len(WLEN_RESET);

endpackage

@@ src/swmd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmd_if: valid/ready channels of the sliding window median block
// Sample channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface swmd_in_if import swmd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface

interface swmd_out_if import swmd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] median_value;
  logic [DSUM_W-1:0]          distance_sum;

  modport source (output valid, output median_value, output distance_sum, input ready);
  modport sink (input valid, input median_value, input distance_sum, output ready);
endinterface

@@ src/swmd_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmd_cell: one cell of the sorted sample chain
// Holds one sample and its age; takes from the left on insert, from the
// right on removal, and reports its distance to the median.
// ----------------------------------------------------------------------------
module swmd_cell import swmd_pkg::*; (
  input  logic              clk_i,
  input  cell_ctl_t         ctl_i,
  input  logic              occ_i,
  input  swmd_link_t        left_i,
  input  swmd_link_t        right_i,
  output swmd_link_t        link_o,
  output logic              hit_o,
  output logic [DIST_W-1:0] dist_o
);

  logic signed [SAMPLE_W-1:0] val_q;
  logic [IDX_W-1:0]           age_q;
  logic                       gt;
  logic                       ge_rem;
  logic [SAMPLE_W:0]          diff_a;
  logic [SAMPLE_W:0]          diff_b;

  // Empty cells count as larger than any sample.
  assign gt     = !occ_i || ($signed(val_q) > $signed(ctl_i.x));
  assign ge_rem = $signed(val_q) >= $signed(ctl_i.r);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ins) begin
      if (!gt) begin
        age_q <= age_q + IDX_W'(1);
      end else if (!left_i.gt) begin
        val_q <= ctl_i.x;
        age_q <= '0;
      end else begin
        val_q <= left_i.val;
        age_q <= left_i.age + IDX_W'(1);
      end
    end else if (ctl_i.rem && ge_rem) begin
      val_q <= right_i.val;
      age_q <= right_i.age;
    end
  end

  assign link_o.val = val_q;
  assign link_o.age = age_q;
  assign link_o.gt  = gt;

  assign hit_o = occ_i && (age_q == ctl_i.oldest);

  // Both differences in parallel, pick the non-negative one.
  assign diff_a = {val_q[SAMPLE_W-1], val_q} - {ctl_i.med[SAMPLE_W-1], ctl_i.med};
  assign diff_b = {ctl_i.med[SAMPLE_W-1], ctl_i.med} - {val_q[SAMPLE_W-1], val_q};
  assign dist_o = !occ_i ? '0 :
                  diff_a[SAMPLE_W] ? diff_b[DIST_W-1:0] : diff_a[DIST_W-1:0];

endmodule

@@ src/swmd_sum_tree.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmd_sum_tree: registered adder tree over the cell distances
// One register level per tree level; the median travels alongside.
// ----------------------------------------------------------------------------
module swmd_sum_tree import swmd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tree_ctl_t                  ctl_i,
  input  logic signed [SAMPLE_W-1:0] med_i,
  input  logic [DIST_W-1:0]          dist_i [MAX_WINDOW],
  output logic                       valid_o,
  output logic signed [SAMPLE_W-1:0] med_o,
  output logic [DSUM_W-1:0]          sum_o
);

  logic [DSUM_W-1:0]          node_q [TREE_NODES];
  logic                       vld_q  [TREE_LEVELS+1];
  logic signed [SAMPLE_W-1:0] med_q  [TREE_LEVELS+1];

  for (genvar n = 0; n < TREE_LEAVES - 1; n++) begin : g_node
    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        node_q[n] <= node_q[2*n+1] + node_q[2*n+2];
      end
    end
  end

  for (genvar j = 0; j < TREE_LEAVES; j++) begin : g_leaf
    always_ff @(posedge clk_i) begin
      if (ctl_i.adv && ctl_i.load) begin
        if (j < MAX_WINDOW) begin
          node_q[TREE_LEAVES-1+j] <= DSUM_W'(dist_i[j]);
        end else begin
          node_q[TREE_LEAVES-1+j] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_q[0] <= ctl_i.load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv && ctl_i.load) begin
      med_q[0] <= med_i;
    end
  end

  for (genvar k = 1; k <= TREE_LEVELS; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.adv) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        med_q[k] <= med_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[TREE_LEVELS];
  assign med_o   = med_q[TREE_LEVELS];
  assign sum_o   = node_q[0];

endmodule

@@ src/sliding_window_median_deviation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_deviation: windowed lower median and deviation sum
// Samples enter on smp_i; once the window of window_length samples is full,
// each sample yields the lower median and the sum of absolute distances to
// it on res_o, then the oldest sample leaves. restart empties the window
// before its sample enters. window_length (0 acts as 1, above 64 as 64) is
// written over the APB port at address 0; any write to it empties the window.
// Both channels transfer on valid and ready high at a rising edge.
// Throughput: one sample per cycle while the window fills. Once it is full,
// each sample is first inserted into the sorted cell chain; then an
// evaluation step selects the median, captures every cell distance and
// removes the oldest cell; smp_i.ready is low during that evaluation step.
// Path: res_o.valid rises once its sample has passed the evaluation step,
// which loads the tree leaves, and the six adder levels of the distance tree.
// Reset: window empty, window_length 3, no result pending.
// Stall: while res_o waits, the tree and the median pipe hold; samples that
// do not fill the window keep being taken, a full window waits.
// ----------------------------------------------------------------------------
module sliding_window_median_deviation import swmd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  swmd_in_if.sink            smp_i,
  swmd_out_if.source         res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_e;

  state_e                     state_q;
  logic [LEN_W-1:0]           fill_q;
  logic [WLEN_W-1:0]          wlen_q;
  logic [LEN_W-1:0]           len_q;
  logic [IDX_W-1:0]           mid_q;
  logic [IDX_W-1:0]           oldest_q;

  logic                       cfg_we;
  logic [LEN_W-1:0]           cfg_len;
  logic                       accept;
  logic                       adv;
  logic                       rem;
  logic [LEN_W-1:0]           fill_eff;
  logic [LEN_W-1:0]           fill_ins;
  logic [LEN_W-1:0]           fill_sel;
  logic [MAX_WINDOW-1:0]      occ;
  logic [MAX_WINDOW-1:0]      hit;
  logic signed [SAMPLE_W-1:0] med_val;
  logic signed [SAMPLE_W-1:0] rem_val;
  cell_ctl_t                  cell_ctl;
  tree_ctl_t                  tree_ctl;
  swmd_link_t                 link      [MAX_WINDOW];
  logic [DIST_W-1:0]          cell_dist [MAX_WINDOW];

  // Configuration port: zero wait states, one register.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_WINDOW_LENGTH);
  assign cfg_len = clamp_len(pwdata[WLEN_W-1:0]);
  assign prdata  = (paddr[PADDR_W-1] == REG_WINDOW_LENGTH) ? PDATA_W'(wlen_q) : '0;

  // Take a sample only between evaluations.
  assign smp_i.ready = (state_q == ST_IDLE);
  assign accept      = smp_i.valid && smp_i.ready;

  // Advance the tree whenever the result register is free or drains.
  assign adv = !res_o.valid || res_o.ready;
  assign rem = (state_q == ST_EVAL) && adv;

  // Restart, or a stale count, empties the window before insertion.
  assign fill_eff = (smp_i.restart || (fill_q >= len_q)) ? '0 : fill_q;
  assign fill_ins = fill_eff + LEN_W'(1);
  assign fill_sel = (state_q == ST_EVAL) ? fill_q : fill_eff;

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      occ[i] = LEN_W'(i) < fill_sel;
    end
  end

  // Broadcast the median and the oldest sample from their cells.
  always_comb begin
    med_val = '0;
    rem_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      med_val = med_val | ((mid_q == IDX_W'(i)) ? link[i].val : '0);
      rem_val = rem_val | (hit[i] ? link[i].val : '0);
    end
  end

  assign cell_ctl.ins    = accept;
  assign cell_ctl.rem    = rem;
  assign cell_ctl.x      = smp_i.sample;
  assign cell_ctl.r      = rem_val;
  assign cell_ctl.med    = med_val;
  assign cell_ctl.oldest = oldest_q;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swmd_link_t left_in;
    swmd_link_t right_in;

    // The head reads as a cell at or below any sample.
    if (i == 0) begin : g_head
      assign left_in = '{val: '0, age: '0, gt: 1'b0};
    end else begin : g_body
      assign left_in = link[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_tail
      assign right_in = '{val: '0, age: '0, gt: 1'b1};
    end else begin : g_next
      assign right_in = link[i+1];
    end

    swmd_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl),
      .occ_i  (occ[i]),
      .left_i (left_in),
      .right_i(right_in),
      .link_o (link[i]),
      .hit_o  (hit[i]),
      .dist_o (cell_dist[i])
    );
  end

  assign tree_ctl.load = rem;
  assign tree_ctl.adv  = adv;

  swmd_sum_tree u_sum_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (tree_ctl),
    .med_i  (med_val),
    .dist_i (cell_dist),
    .valid_o(res_o.valid),
    .med_o  (res_o.median_value),
    .sum_o  (res_o.distance_sum)
  );

  // Sequencer: a window_length write empties the window; otherwise insert, then evaluate and drop the oldest when full.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      wlen_q   <= WLEN_RESET;
      len_q    <= LEN_RESET;
      mid_q    <= len_mid(LEN_RESET);
      oldest_q <= len_last(LEN_RESET);
    end else if (cfg_we) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      wlen_q   <= pwdata[WLEN_W-1:0];
      len_q    <= cfg_len;
      mid_q    <= len_mid(cfg_len);
      oldest_q <= len_last(cfg_len);
    end else if (accept) begin
      fill_q  <= fill_ins;
      state_q <= (fill_ins == len_q) ? ST_EVAL : ST_IDLE;
    end else if (rem) begin
      fill_q  <= fill_q - LEN_W'(1);
      state_q <= ST_IDLE;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= len_q)
    else $error("window fill exceeds window length");

  a_eval_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> (fill_q == len_q))
    else $error("evaluation started on a window that is not full");

  a_oldest_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> $onehot(hit))
    else $error("full window does not hold exactly one oldest cell");

  a_load_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem |=> !smp_i.ready || $past(cfg_we) || (state_q == ST_IDLE))
    else $error("sequencer did not leave evaluation after removal");
`endif

endmodule
